FILE: src/utf8_decode_cluster_mark_unit_assert.svh
// Assertion macros for the checker module.
`ifndef UTF8_DECODE_CLUSTER_MARK_UNIT_ASSERT_SVH
`define UTF8_DECODE_CLUSTER_MARK_UNIT_ASSERT_SVH

// Same-cycle implication, masked during reset.
`define UDCM_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("utf8 decode check failed");

// Next-cycle implication, masked during reset.
`define UDCM_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("utf8 decode check failed");

// Next-cycle implication, checked through reset as well.
`define UDCM_ASSERT_NEXT_ALWAYS(label, clk, ante, cons) \
    label: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error("utf8 decode check failed");

`endif

FILE: src/utf8dcm_pkg.sv
package utf8dcm_pkg;

    localparam int unsigned CP_W  = 21;
    localparam int unsigned OUT_W = 16;

    // Thai combining marks
    localparam logic [CP_W-1:0] THAI_MAI_HAN_AKAT = 21'h000E31;
    localparam logic [CP_W-1:0] THAI_VOWEL_LO     = 21'h000E34;
    localparam logic [CP_W-1:0] THAI_VOWEL_HI     = 21'h000E3A;
    localparam logic [CP_W-1:0] THAI_TONE_LO      = 21'h000E47;
    localparam logic [CP_W-1:0] THAI_TONE_HI      = 21'h000E4E;

    typedef struct packed {
        logic [OUT_W-1:0] next_offset;
        logic [OUT_W-1:0] start_offset;
        logic [CP_W-1:0]  code_point;
        logic             cluster_start;
    } t_result;

    function automatic logic is_cluster_start(input logic [CP_W-1:0] cp);
        logic mark;
        mark = (cp == THAI_MAI_HAN_AKAT) ||
               (cp >= THAI_VOWEL_LO && cp <= THAI_VOWEL_HI) ||
               (cp >= THAI_TONE_LO && cp <= THAI_TONE_HI);
        return !mark;
    endfunction

endpackage

FILE: src/utf8_decode_cluster_mark_unit.sv
// UTF-8 decoder with Thai cluster marking. Takes one text byte per beat
// (tuser = start of text, which zeroes the offset and decoder state before
// that byte) and returns one beat per completed code point with its lead-byte
// offset, the offset after it, and a cluster-start flag that is low for Thai
// combining marks. Stray continuations and bytes 0xF8-0xFF produce no beat;
// a lead byte mid-sequence restarts decoding. Throughput is one byte per cycle
// while the output does not stall, set by the combinational decode step between
// the input and result registers; a result is registered from its last byte in
// the input register. Offsets wrap at OFFSET_WIDTH bits and are reported in 16 bits.
module utf8_decode_cluster_mark_unit #(
    parameter int unsigned OFFSET_WIDTH = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [7:0]  i_s_axis_tdata,   // [7:0] data_byte
    input  logic        i_s_axis_tuser,   // [0] start_of_text
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [55:0] o_m_axis_tdata,   // [20:0] code_point, [36:21] start_offset,
                                          // [52:37] next_offset, [55:53] zero
    output logic        o_m_axis_tuser    // [0] cluster_start
);
    import utf8dcm_pkg::*;

    logic       r_in_valid;
    logic [7:0] r_in_byte;
    logic       r_in_sot;
    logic       r_out_valid;
    t_result    r_out;
    logic       adv;
    logic       emit;
    t_result    res;

    assign adv             = r_in_valid && (!r_out_valid || i_m_axis_tready);
    assign o_s_axis_tready = !r_in_valid || adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_s_axis_tready) begin
            r_in_valid <= i_s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_s_axis_tvalid && o_s_axis_tready) begin
            r_in_byte <= i_s_axis_tdata;
            r_in_sot  <= i_s_axis_tuser;
        end
    end

    utf8dcm_decode #(
        .OFFSET_WIDTH(OFFSET_WIDTH)
    ) u_decode (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_adv  (adv),
        .i_byte (r_in_byte),
        .i_sot  (r_in_sot),
        .o_emit (emit),
        .o_res  (res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (adv) begin
            r_out_valid <= emit;
        end else if (i_m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv && emit) begin
            r_out <= res;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {3'b000, r_out.next_offset, r_out.start_offset, r_out.code_point};
    assign o_m_axis_tuser  = r_out.cluster_start;

endmodule

FILE: src/utf8dcm_decode.sv
module utf8dcm_decode #(
    parameter int unsigned OFFSET_WIDTH = 16
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_adv,
    input  logic [7:0]          i_byte,
    input  logic                i_sot,
    output logic                o_emit,
    output utf8dcm_pkg::t_result o_res
);
    import utf8dcm_pkg::*;

    logic [1:0]              r_pend, n_pend;
    logic [CP_W-1:0]         r_acc, n_acc;
    logic [OFFSET_WIDTH-1:0] r_pos, r_seq, n_seq;

    logic [1:0]              eff_pend;
    logic [CP_W-1:0]         eff_acc;
    logic [OFFSET_WIDTH-1:0] eff_pos, eff_seq, nxt_pos;
    logic [CP_W-1:0]         cp;
    logic [OFFSET_WIDTH-1:0] start;
    logic [31:0]             start_ext, next_ext;
    logic [CP_W-1:0]         shifted;

    // start of text clears everything before this byte
    assign eff_pend = i_sot ? 2'd0 : r_pend;
    assign eff_acc  = i_sot ? '0 : r_acc;
    assign eff_pos  = i_sot ? '0 : r_pos;
    assign eff_seq  = i_sot ? '0 : r_seq;
    assign nxt_pos  = eff_pos + OFFSET_WIDTH'(1);
    assign shifted  = {eff_acc[CP_W-7:0], i_byte[5:0]};

    always_comb begin
        n_pend = eff_pend;
        n_acc  = eff_acc;
        n_seq  = eff_seq;
        o_emit = 1'b0;
        cp     = shifted;
        start  = eff_seq;
        if (!i_byte[7]) begin
            n_pend = 2'd0;
            n_acc  = '0;
            o_emit = 1'b1;
            cp     = CP_W'(i_byte);
            start  = eff_pos;
        end else if (!i_byte[6]) begin
            if (eff_pend != 2'd0) begin
                n_acc  = shifted;
                n_pend = eff_pend - 2'd1;
                o_emit = (eff_pend == 2'd1);
            end
        end else if (i_byte[7:5] == 3'b110) begin
            n_pend = 2'd1;
            n_acc  = CP_W'(i_byte[4:0]);
            n_seq  = eff_pos;
        end else if (i_byte[7:4] == 4'b1110) begin
            n_pend = 2'd2;
            n_acc  = CP_W'(i_byte[3:0]);
            n_seq  = eff_pos;
        end else if (i_byte[7:3] == 5'b11110) begin
            n_pend = 2'd3;
            n_acc  = CP_W'(i_byte[2:0]);
            n_seq  = eff_pos;
        end
        // 0xF8-0xFF: state held, only the offset moves
    end

    assign start_ext = 32'(start);
    assign next_ext  = 32'(nxt_pos);

    always_comb begin
        o_res.code_point    = cp;
        o_res.start_offset  = start_ext[OUT_W-1:0];
        o_res.next_offset   = next_ext[OUT_W-1:0];
        o_res.cluster_start = is_cluster_start(cp);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend <= 2'd0;
            r_acc  <= '0;
            r_pos  <= '0;
            r_seq  <= '0;
        end else if (i_adv) begin
            r_pend <= n_pend;
            r_acc  <= n_acc;
            r_pos  <= nxt_pos;
            r_seq  <= n_seq;
        end
    end

endmodule

FILE: src/utf8dcm_checker.sv
`include "utf8_decode_cluster_mark_unit_assert.svh"

module utf8dcm_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_s_axis_tready,
    input logic        o_m_axis_tvalid,
    input logic        i_m_axis_tready,
    input logic [55:0] o_m_axis_tdata,
    input logic        o_m_axis_tuser
);
    import utf8dcm_pkg::*;

    logic stall;
    logic flag_ok;

    assign stall   = o_m_axis_tvalid && !i_m_axis_tready;
    assign flag_ok = (o_m_axis_tuser == is_cluster_start(o_m_axis_tdata[CP_W-1:0]));

    // a stalled result beat holds
    `UDCM_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, stall,
        o_m_axis_tvalid && $stable(o_m_axis_tdata) && $stable(o_m_axis_tuser))
    // reset leaves no result pending
    `UDCM_ASSERT_NEXT_ALWAYS(a_rst_empty, i_clk, !i_rst_n, !o_m_axis_tvalid)
    // with the result slot empty the input side never backs up
    `UDCM_ASSERT_NOW(a_ready_free, i_clk, i_rst_n, !o_m_axis_tvalid, o_s_axis_tready)
    // cluster flag matches the Thai mark ranges
    `UDCM_ASSERT_NOW(a_flag, i_clk, i_rst_n, o_m_axis_tvalid, flag_ok)

endmodule

bind utf8_decode_cluster_mark_unit utf8dcm_checker u_utf8dcm_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .o_s_axis_tready(o_s_axis_tready),
    .o_m_axis_tvalid(o_m_axis_tvalid),
    .i_m_axis_tready(i_m_axis_tready),
    .o_m_axis_tdata (o_m_axis_tdata),
    .o_m_axis_tuser (o_m_axis_tuser)
);
